FILE: rtl/scw_pkg.sv
// Shared constants for the scan line curvature window.
package scw_pkg;

    // Sequence number carried with every point
    localparam int SEQ_BITS = 16;
    // Point index and curvature fields of a result
    localparam int IDX_OUT_BITS = 16;
    localparam int CURV_BITS = 46;
    // Result tdata: point_index and curvature, padded to whole bytes
    localparam int OUT_DATA_BITS = ((IDX_OUT_BITS + CURV_BITS + 7) / 8) * 8;

endpackage

FILE: rtl/scanline_curvature_window.sv
// Scan line curvature window: sliding window over lidar points, curvature per centre point.
//
// Points of one scan line stream in on the slave side, one request per clock when the
// result side keeps up. A point with tuser set starts a new line and empties the window.
// A point that fills or follows a full window of 2*HALF_WINDOW+1 points of the line yields
// one result for the point HALF_WINDOW places back: for x, y and z the ten neighbours are
// summed less ten times the centre (a running window sum less (2*HALF_WINDOW+1) times the
// centre), the three differences are squared and added, saturating at 2^46-1. tuser of the
// result is 1 when the sequence numbers at the window ends differ by exactly 2*HALF_WINDOW;
// otherwise the curvature field is zero. Throughput is one point per clock while results
// are taken; a result reaches the master side from the edge that accepts the point
// completing its window through the window register at that edge, then difference stage,
// squaring stage, and sum and saturate into the output register. The whole pipeline stalls
// only while a result is held on the master side without tready.
module scanline_curvature_window #(
    parameter int HALF_WINDOW = 5,
    parameter int COORD_BITS  = 19,
    parameter int INDEX_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave side: point requests
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // fields from bit 0: pos_x, pos_y, pos_z (COORD_BITS each), seq_number, zero padding
    input  logic [((3 * COORD_BITS + scw_pkg::SEQ_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // fields: line_start
    input  logic i_s_tuser,
    // master side: curvature results
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // fields from bit 0: point_index, curvature, zero padding
    output logic [scw_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    // fields: curv_valid
    output logic o_m_tuser
);
    import scw_pkg::*;

    localparam int WIN_LEN   = 2 * HALF_WINDOW + 1;
    localparam int FILL_BITS = $clog2(WIN_LEN + 1);
    localparam int SUM_BITS  = COORD_BITS + $clog2(WIN_LEN) + 1;
    localparam int SQ_BITS   = 2 * SUM_BITS;
    localparam int TOT_BITS  = SQ_BITS + 2;
    localparam int ACC_BITS  = (TOT_BITS > CURV_BITS) ? TOT_BITS : CURV_BITS;
    localparam int PAD_BITS  = OUT_DATA_BITS - IDX_OUT_BITS - CURV_BITS;

    // window storage: coordinates and sequence numbers (no reset, fill count qualifies them)
    logic signed [COORD_BITS-1:0] r_win [WIN_LEN][3];
    logic [SEQ_BITS-1:0]          r_seq [WIN_LEN];
    logic signed [SUM_BITS-1:0]   r_sum [3];
    logic [FILL_BITS-1:0]         r_fill;
    logic [INDEX_BITS-1:0]        r_pos;

    // pipeline stages
    logic                         r_a_valid;
    logic [IDX_OUT_BITS-1:0]      r_a_idx;
    logic                         r_b_valid;
    logic                         r_b_cv;
    logic [IDX_OUT_BITS-1:0]      r_b_idx;
    logic signed [SUM_BITS-1:0]   r_b_d [3];
    logic                         r_c_valid;
    logic                         r_c_cv;
    logic [IDX_OUT_BITS-1:0]      r_c_idx;
    logic [SQ_BITS-1:0]           r_c_sq [3];
    logic                         r_out_valid;
    logic                         r_out_cv;
    logic [IDX_OUT_BITS-1:0]      r_out_idx;
    logic [CURV_BITS-1:0]         r_out_curv;

    logic                         advance;
    logic                         accept;
    logic                         line_start;
    logic signed [COORD_BITS-1:0] in_coord [3];
    logic [SEQ_BITS-1:0]          in_seq;
    logic [INDEX_BITS-1:0]        cur_pos;
    logic [INDEX_BITS-1:0]        n_pos;
    logic [INDEX_BITS-1:0]        centre_pos;
    logic [INDEX_BITS+IDX_OUT_BITS-1:0] centre_pos_ext;
    logic [FILL_BITS-1:0]         n_fill;
    logic                         win_full;
    logic signed [SUM_BITS-1:0]   n_sum [3];
    logic [SEQ_BITS-1:0]          span;
    logic                         seq_ok;
    logic signed [SUM_BITS-1:0]   diff [3];
    logic [SUM_BITS-1:0]          mag [3];
    logic [ACC_BITS-1:0]          acc;

    // the whole pipeline moves whenever the output register is free or being taken
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = advance;
    assign accept     = i_s_tvalid && advance;

    // unpack the request
    assign line_start  = i_s_tuser;
    assign in_coord[0] = i_s_tdata[COORD_BITS-1:0];
    assign in_coord[1] = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_coord[2] = i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_seq      = i_s_tdata[3*COORD_BITS+SEQ_BITS-1:3*COORD_BITS];

    // line position, fill count and running window sums
    always_comb begin
        cur_pos        = line_start ? '0 : r_pos;
        n_pos          = cur_pos + INDEX_BITS'(1);
        centre_pos     = cur_pos - INDEX_BITS'(HALF_WINDOW);
        centre_pos_ext = {{IDX_OUT_BITS{1'b0}}, centre_pos};
        win_full       = !line_start && (r_fill == FILL_BITS'(WIN_LEN));
        n_fill         = line_start ? '0 : r_fill;
        if (n_fill < FILL_BITS'(WIN_LEN)) begin
            n_fill = n_fill + FILL_BITS'(1);
        end
        for (int c = 0; c < 3; c++) begin
            // the oldest entry only leaves the sum once the window holds a full line segment
            n_sum[c] = (line_start ? SUM_BITS'(0) : r_sum[c]) + SUM_BITS'(in_coord[c])
                       - (win_full ? SUM_BITS'(r_win[0][c]) : SUM_BITS'(0));
        end
    end

    // window shift on every accepted point
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
                r_seq[i] <= r_seq[i+1];
            end
            r_win[WIN_LEN-1] <= in_coord;
            r_seq[WIN_LEN-1] <= in_seq;
        end
    end

    // window control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pos  <= '0;
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= '0;
            end
        end else if (accept) begin
            r_fill <= n_fill;
            r_pos  <= n_pos;
            r_sum  <= n_sum;
        end
    end

    // centre differences from the registered window, stage B magnitudes and the stage C square sum
    always_comb begin
        span   = r_seq[WIN_LEN-1] - r_seq[0];
        seq_ok = (span == SEQ_BITS'(2 * HALF_WINDOW));
        for (int c = 0; c < 3; c++) begin
            diff[c] = r_sum[c] - SUM_BITS'(r_win[HALF_WINDOW][c]) * SUM_BITS'(WIN_LEN);
            mag[c]  = r_b_d[c][SUM_BITS-1] ? SUM_BITS'(-r_b_d[c]) : SUM_BITS'(r_b_d[c]);
        end
        acc = ACC_BITS'(r_c_sq[0]) + ACC_BITS'(r_c_sq[1]) + ACC_BITS'(r_c_sq[2]);
    end

    // pipeline stages and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid   <= accept && (n_fill == FILL_BITS'(WIN_LEN));
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_idx <= centre_pos_ext[IDX_OUT_BITS-1:0];
            // stage B: differences, forced to zero when neighbours are not contiguous
            r_b_idx <= r_a_idx;
            r_b_cv  <= seq_ok;
            for (int c = 0; c < 3; c++) begin
                r_b_d[c] <= seq_ok ? diff[c] : SUM_BITS'(0);
            end
            // stage C: squares
            r_c_idx <= r_b_idx;
            r_c_cv  <= r_b_cv;
            for (int c = 0; c < 3; c++) begin
                r_c_sq[c] <= SQ_BITS'(mag[c]) * SQ_BITS'(mag[c]);
            end
            // output: sum with saturation
            r_out_idx <= r_c_idx;
            r_out_cv  <= r_c_cv;
            if (acc > ACC_BITS'({CURV_BITS{1'b1}})) begin
                r_out_curv <= {CURV_BITS{1'b1}};
            end else begin
                r_out_curv <= acc[CURV_BITS-1:0];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_BITS{1'b0}}, r_out_curv, r_out_idx};
    assign o_m_tuser  = r_out_cv;

`ifndef SYNTHESIS
    // fill count never passes the window length
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(WIN_LEN))
        else $error("fill count beyond window length");

    // a line start leaves exactly one point in the window
    a_line_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && line_start |=> r_fill == FILL_BITS'(1) && !r_a_valid)
        else $error("line start did not restart the window");

    // a point that fills or follows a full window scores a centre point
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !line_start && r_fill >= FILL_BITS'(WIN_LEN - 1) |=> r_a_valid)
        else $error("full window produced no result");

    // non-contiguous results carry zero curvature
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_cv |-> r_out_curv == '0)
        else $error("curvature set on non-contiguous result");

    // a result held in stage A reaches stage B when the pipeline advances
    a_stage_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_a_valid |=> r_b_valid)
        else $error("result lost between stages");
`endif

endmodule

FILE: bench/scw_result_checker.sv
// Result checker for the scan line curvature window: predicts each curvature and compares.
`timescale 1ns / 100ps

module scw_result_checker #(
    parameter int HALF_WINDOW = 5,
    parameter int COORD_BITS  = 19,
    parameter int INDEX_BITS  = 16,
    parameter int IN_BITS     = 80
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // point requests as seen on the slave side
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // fields from bit 0: pos_x, pos_y, pos_z, seq_number, zero padding
    input  logic [IN_BITS-1:0]                i_s_tdata,
    // fields: line_start
    input  logic                              i_s_tuser,
    // result requests as seen on the master side
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // fields from bit 0: point_index, curvature, zero padding
    input  logic [scw_pkg::OUT_DATA_BITS-1:0] i_m_tdata,
    // fields: curv_valid
    input  logic                              i_m_tuser,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int SPAN      = 2 * HALF_WINDOW;
    localparam int WIN_LEN   = SPAN + 1;
    localparam int SEQ_BITS  = scw_pkg::SEQ_BITS;
    localparam int CURV_BITS = scw_pkg::CURV_BITS;
    localparam int IDX_BITS  = scw_pkg::IDX_OUT_BITS;
    localparam longint unsigned CURV_CEILING = (64'd1 << CURV_BITS) - 64'd1;

    typedef struct packed {
        logic [IDX_BITS-1:0]  point_index;
        logic [CURV_BITS-1:0] curvature;
        logic                 curv_valid;
    } curv_result_t;

    // predictor state: points held for the current line
    logic signed [COORD_BITS-1:0] held_x [WIN_LEN];
    logic signed [COORD_BITS-1:0] held_y [WIN_LEN];
    logic signed [COORD_BITS-1:0] held_z [WIN_LEN];
    logic [SEQ_BITS-1:0]          held_seq [WIN_LEN];
    int                           points_held;
    logic [INDEX_BITS-1:0]        next_position;

    curv_result_t awaited_curvatures [$];

    task automatic empty_window();
        held_x        = '{default: '0};
        held_y        = '{default: '0};
        held_z        = '{default: '0};
        held_seq      = '{default: '0};
        points_held   = 0;
        next_position = '0;
    endtask

    // sum of the neighbours less SPAN times the centre, for one axis
    function automatic longint signed axis_offset(input logic signed [COORD_BITS-1:0] w [WIN_LEN]);
        longint signed acc;
        acc = 0;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (i != HALF_WINDOW)
                acc += longint'(w[i]);
        end
        acc -= longint'(SPAN) * longint'(w[HALF_WINDOW]);
        return acc;
    endfunction

    // shift one point in and work out the result it causes, if any
    task automatic take_point(input logic start, input logic [IN_BITS-1:0] data,
                              output bit produced, output curv_result_t res);
        logic [INDEX_BITS-1:0] here;
        logic [SEQ_BITS-1:0]   seq_span;
        longint signed         dx, dy, dz;
        longint unsigned       total;
        if (start)
            empty_window();
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            held_x[i]   = held_x[i + 1];
            held_y[i]   = held_y[i + 1];
            held_z[i]   = held_z[i + 1];
            held_seq[i] = held_seq[i + 1];
        end
        held_x[WIN_LEN - 1]   = data[COORD_BITS-1:0];
        held_y[WIN_LEN - 1]   = data[2*COORD_BITS-1:COORD_BITS];
        held_z[WIN_LEN - 1]   = data[3*COORD_BITS-1:2*COORD_BITS];
        held_seq[WIN_LEN - 1] = data[3*COORD_BITS+SEQ_BITS-1:3*COORD_BITS];
        here          = next_position;
        next_position = next_position + 1'b1;
        if (points_held < WIN_LEN)
            points_held++;
        produced = (points_held == WIN_LEN);
        res      = '0;
        if (produced) begin
            seq_span        = held_seq[WIN_LEN - 1] - held_seq[0];
            res.point_index = IDX_BITS'(here - INDEX_BITS'(HALF_WINDOW));
            res.curv_valid  = (seq_span == SEQ_BITS'(SPAN));
            if (res.curv_valid) begin
                dx    = axis_offset(held_x);
                dy    = axis_offset(held_y);
                dz    = axis_offset(held_z);
                total = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
                if (total > CURV_CEILING)
                    total = CURV_CEILING;
                res.curvature = total[CURV_BITS-1:0];
            end
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        empty_window();
    end

    // watch both channels at every rising edge
    always @(posedge i_clk) begin
        curv_result_t want, got;
        bit           produced;
        if (!i_rst_n) begin
            empty_window();
            awaited_curvatures.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                take_point(i_s_tuser, i_s_tdata, produced, want);
                if (produced)
                    awaited_curvatures.insert(awaited_curvatures.size(), want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.point_index = i_m_tdata[IDX_BITS-1:0];
                got.curvature   = i_m_tdata[IDX_BITS+CURV_BITS-1:IDX_BITS];
                got.curv_valid  = i_m_tuser;
                if (awaited_curvatures.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with none expected, point_index %0d curvature %0d",
                             $time, got.point_index, got.curvature);
                end else begin
                    want = awaited_curvatures.pop_front();
                    if (got.point_index !== want.point_index) begin
                        o_fail_count++;
                        $display("%0t: point_index expected %0d actual %0d",
                                 $time, want.point_index, got.point_index);
                    end
                    if (got.curvature !== want.curvature) begin
                        o_fail_count++;
                        $display("%0t: curvature at %0d expected %0d actual %0d",
                                 $time, want.point_index, want.curvature, got.curvature);
                    end
                    if (got.curv_valid !== want.curv_valid) begin
                        o_fail_count++;
                        $display("%0t: curv_valid at %0d expected %0b actual %0b",
                                 $time, want.point_index, want.curv_valid, got.curv_valid);
                    end
                end
            end
        end
        o_pending = awaited_curvatures.size();
    end

endmodule

FILE: bench/tb_scanline_curvature_window.sv
// Testbench top for the scan line curvature window: point stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_scanline_curvature_window;

    localparam int HALF_WINDOW = 5;
    localparam int COORD_BITS  = 19;
    localparam int INDEX_BITS  = 16;
    localparam int IN_BITS     = ((3 * COORD_BITS + scw_pkg::SEQ_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1150;
    localparam int LONG_LINE    = 130;
    localparam int DRAIN_CYCLES = 24;
    localparam longint CYCLE_LIMIT = 3_000_000;

    localparam logic [COORD_BITS-1:0] C_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] C_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] C_NEG1 = '1;

    // idling modes for either side
    typedef enum int { IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY } idle_mode_t;
    // coordinate styles of a line
    typedef enum int { COORD_FULL, COORD_SURFACE, COORD_EXTREME } coord_style_t;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_tvalid;
    logic                              o_s_tready;
    logic [IN_BITS-1:0]                i_s_tdata;
    logic                              i_s_tuser;
    logic                              o_m_tvalid;
    logic                              i_m_tready;
    logic [scw_pkg::OUT_DATA_BITS-1:0] o_m_tdata;
    logic                              o_m_tuser;

    int         fail_count;
    int         pending;
    idle_mode_t gap_mode;
    idle_mode_t ready_mode;
    int         stall_left;
    longint     cycle_count;

    scanline_curvature_window #(
        .HALF_WINDOW (HALF_WINDOW),
        .COORD_BITS  (COORD_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    scw_result_checker #(
        .HALF_WINDOW (HALF_WINDOW),
        .COORD_BITS  (COORD_BITS),
        .INDEX_BITS  (INDEX_BITS),
        .IN_BITS     (IN_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_scanline_curvature_window NOT OK");
            $finish;
        end
    end

    // stall length for the result side; zero means stay ready
    function automatic int pick_stall(input idle_mode_t mode);
        case (mode)
            IDLE_LIGHT: return ($urandom_range(0, 99) < 5) ? $urandom_range(1, 2) : 0;
            IDLE_HEAVY: begin
                if ($urandom_range(0, 99) >= 25)
                    return 0;
                return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            end
            default: return 0;
        endcase
    endfunction

    // gap before a point request
    function automatic int pick_gap(input idle_mode_t mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            IDLE_LIGHT: return (roll < 90) ? 0 : $urandom_range(1, 2);
            IDLE_HEAVY: begin
                if (roll < 60)
                    return 0;
                return (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            end
            default: return 0;
        endcase
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(input coord_style_t style,
                                                         input logic [COORD_BITS-1:0] base);
        case (style)
            COORD_SURFACE: return base + COORD_BITS'($urandom_range(0, 64)) - COORD_BITS'(32);
            COORD_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    3: return C_NEG1;
                    default: return COORD_BITS'($urandom);
                endcase
            end
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // result side back-pressure, changed at the falling edge
    always @(negedge i_clk) begin
        if (stall_left == 0)
            stall_left = pick_stall(ready_mode);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
    endtask

    // one point request, held until accepted
    task automatic send_point(input logic start, input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py, input logic [COORD_BITS-1:0] pz,
                              input logic [scw_pkg::SEQ_BITS-1:0] seq);
        hold_off(pick_gap(gap_mode));
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= start;
        i_s_tdata  <= IN_BITS'({seq, pz, py, px});
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    initial begin
        int                           sent;
        int                           len;
        int                           k;
        bit                           noisy;
        bit                           flagged;
        coord_style_t                 style;
        logic [COORD_BITS-1:0]        bx, by, bz;
        logic [scw_pkg::SEQ_BITS-1:0] seq;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        stall_left = 0;
        gap_mode   = IDLE_HEAVY;
        ready_mode = IDLE_HEAVY;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // points before any line start; a minimum centre among maximum neighbours saturates
        for (k = 0; k < 12; k++) begin
            if (k == HALF_WINDOW)
                send_point(1'b0, C_MIN, C_MIN, C_MIN, 16'(k));
            else
                send_point(1'b0, C_MAX, C_MAX, C_MAX, 16'(k));
        end

        // line start with sequence numbers wrapping, then a break in the sequence
        seq = 16'hFFFA;
        for (k = 0; k < 12; k++) begin
            if (k == HALF_WINDOW)
                send_point(k == 0, C_MAX, C_NEG1, '0, seq);
            else
                send_point(k == 0, C_MIN, '0, COORD_BITS'($urandom), seq);
            seq = (k == 10) ? seq + 16'd5 : seq + 16'd1;
        end

        // one long unbroken line with light idling on both sides
        gap_mode   = IDLE_LIGHT;
        ready_mode = IDLE_LIGHT;
        seq        = 16'($urandom);
        for (k = 0; k < LONG_LINE; k++) begin
            send_point(k == 0, COORD_BITS'($urandom), COORD_BITS'($urandom),
                       COORD_BITS'($urandom), seq);
            seq = seq + 16'd1;
        end

        // random lines: mostly contiguous, some noisy, some too short to score
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2:    len = $urandom_range(1, 2 * HALF_WINDOW);
                3, 4, 5:    len = $urandom_range(41, 120);
                default:    len = $urandom_range(2 * HALF_WINDOW + 1, 40);
            endcase
            noisy      = ($urandom_range(0, 3) == 0);
            flagged    = ($urandom_range(0, 9) != 0);
            style      = coord_style_t'($urandom_range(0, 2));
            gap_mode   = idle_mode_t'($urandom_range(0, 2));
            ready_mode = idle_mode_t'($urandom_range(0, 2));
            bx         = COORD_BITS'($urandom);
            by         = COORD_BITS'($urandom);
            bz         = COORD_BITS'($urandom);
            seq        = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65520, 65535))
                                                     : 16'($urandom);
            for (k = 0; k < len; k++) begin
                send_point(flagged && (k == 0), pick_coord(style, bx), pick_coord(style, by),
                           pick_coord(style, bz), seq);
                sent++;
                if (noisy && ($urandom_range(0, 4) == 0))
                    seq = 16'($urandom);
                else if (!noisy && ($urandom_range(0, 32) == 0))
                    seq = seq + 16'($urandom_range(0, 2)) * 16'd2;
                else
                    seq = seq + 16'd1;
            end
        end

        // drain: no more requests, result side always ready
        hold_off(1);
        ready_mode = IDLE_NONE;
        @(negedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_scanline_curvature_window OK");
        else
            $display("tb_scanline_curvature_window NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/scw_pkg.sv
rtl/scanline_curvature_window.sv
bench/scw_result_checker.sv
bench/tb_scanline_curvature_window.sv
